/* rtl/core/km3d_pkg.sv */
// Package for the 3D k-means clustering unit: sizes, opcodes, result kinds and the
// configuration register indexes used by all modules but the RAM. No dependencies.
`timescale 1ns / 1ps
package km3d_pkg;
    localparam int MaxPoints   = 4096;
    localparam int MaxClusters = 16;
    localparam int PtAw        = $clog2(MaxPoints);
    localparam int ClAw        = $clog2(MaxClusters);
    localparam int CntW        = PtAw + 1;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CENTER  = 2'd0;
    localparam t_kind KIND_LABEL   = 2'd1;
    localparam t_kind KIND_K_ZERO  = 2'd2;
    localparam t_kind KIND_K_LARGE = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_K      = 2'd0;
    localparam t_cfg_idx CFG_THRESH = 2'd1;
    localparam t_cfg_idx CFG_ITERS  = 2'd2;

    localparam logic OpLoad = 1'b0;
    localparam logic OpRead = 1'b1;
endpackage

/* rtl/core/km3d_ram.sv */
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module km3d_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/km3d_div.sv */
// Restoring signed divider: 48-bit sum by 13-bit count, truncated toward
// zero, one quotient bit per cycle. Depends on km3d_pkg.
`timescale 1ns / 1ps
module km3d_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [47:0]         i_num,
    input  logic [km3d_pkg::CntW-1:0]  i_den,
    output logic                       o_busy,
    output logic signed [31:0]         o_quot
);
    import km3d_pkg::*;
    logic [47:0]     r_q, n_q;
    logic [CntW:0]   r_rem, n_rem;
    logic [5:0]      r_cnt;
    logic            r_neg;
    logic            r_busy;
    logic [CntW-1:0] r_den;
    logic [CntW:0]   w_trial;
    logic [47:0]     w_neg_q;

    always_comb begin
        w_trial = {r_rem[CntW-1:0], r_q[47]};
        n_q     = {r_q[46:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = w_trial - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
        w_neg_q = 48'd0 - r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd48;
            r_q    <= i_num[47] ? 48'd0 - i_num : i_num;
            r_neg  <= i_num[47];
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? w_neg_q[31:0] : r_q[31:0];
endmodule

/* rtl/core/kmeans_3d_point_clustering_unit.sv */
// Top level of the 3D k-means clustering unit: point memories, label memory,
// sequencer for Lloyd passes. Depends on km3d_pkg, km3d_ram and km3d_div.
//
// Input channel (valid/stall): opcode 0 loads a point into the next store
// slot, one transaction per cycle back to back while no result is pending.
// final_point on a load starts a run over all loaded points. Opcode 1 reads
// a point's label; the label memory is read at acceptance and the reply is
// registered from the S_LBL state. A run with k centres first fetches the
// initial centres, then per pass clears the sums, assigns each point (fetch
// the point, per centre one squared difference per axis then the compare,
// then accumulate), and per cluster runs an update state; a non-empty
// cluster also divides each axis and checks the move. Then come k report
// transactions, one per cycle when the receiver does not stall.
// The input is stalled while a run or a reply is in progress.
// Output channel (valid/stall): one result held in an output register until
// taken; a stall holds it and the sequencer waits.
// Reset clears the loaded count, output valid and sequencer state and sets
// the configuration to defaults; memory contents are undefined until written.
`timescale 1ns / 1ps
module kmeans_3d_point_clustering_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic [11:0] i_point_index,
    input  logic        i_final_point,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_cluster,
    output logic [31:0] o_center_x,
    output logic [31:0] o_center_y,
    output logic [31:0] o_center_z,
    output logic [12:0] o_member_count,
    output logic [7:0]  o_passes_used,
    output logic        o_converged,
    output logic        o_last
);
    import km3d_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_LBL    = 12'b000000000010,
        S_INIT   = 12'b000000000100,
        S_PCLR   = 12'b000000001000,
        S_PT     = 12'b000000010000,
        S_CMP    = 12'b000000100000,
        S_ACC    = 12'b000001000000,
        S_UPD    = 12'b000010000000,
        S_DIV    = 12'b000100000000,
        S_DCHK   = 12'b001000000000,
        S_REP    = 12'b010000000000,
        S_ERR    = 12'b100000000000
    } t_state;

    t_state r_state;
    logic [4:0]  r_k_cfg;
    logic [31:0] r_thresh;
    logic [7:0]  r_iters;
    logic [CntW-1:0] r_n;
    logic [CntW-1:0] r_k;       // effective k
    logic [PtAw-1:0] r_pi;      // point index in a pass
    logic [ClAw:0]   r_cj;      // cluster index
    logic [1:0]      r_axis;
    logic [1:0]      r_ph;      // pipeline phase inside a state
    logic [7:0]  r_passes;
    logic        r_moved, r_conv;
    logic [65:0] r_best_d;
    logic [ClAw-1:0] r_best;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [31:0] r_nx, r_ny, r_nz;
    logic [3:0]  r_err_kind;

    // Centre and accumulator files are small and read at one index a cycle.
    logic signed [31:0] r_cx [MaxClusters];
    logic signed [31:0] r_cy [MaxClusters];
    logic signed [31:0] r_cz [MaxClusters];
    logic signed [47:0] r_sx [MaxClusters];
    logic signed [47:0] r_sy [MaxClusters];
    logic signed [47:0] r_sz [MaxClusters];
    logic [CntW-1:0]    r_mc [MaxClusters];

    // Point and label memories.
    logic            w_pwe;
    logic [PtAw-1:0] w_pwa, w_pra;
    logic [31:0]     w_rx, w_ry, w_rz;
    logic            w_lwe;
    logic [3:0]      w_lrd;
    logic [PtAw-1:0] w_lra;

    km3d_ram #(.Width(32), .Depth(MaxPoints)) u_mx (.i_clk, .i_we(w_pwe),
        .i_waddr(w_pwa), .i_wdata(i_coord_x), .i_raddr(w_pra), .o_rdata(w_rx));
    km3d_ram #(.Width(32), .Depth(MaxPoints)) u_my (.i_clk, .i_we(w_pwe),
        .i_waddr(w_pwa), .i_wdata(i_coord_y), .i_raddr(w_pra), .o_rdata(w_ry));
    km3d_ram #(.Width(32), .Depth(MaxPoints)) u_mz (.i_clk, .i_we(w_pwe),
        .i_waddr(w_pwa), .i_wdata(i_coord_z), .i_raddr(w_pra), .o_rdata(w_rz));
    km3d_ram #(.Width(4), .Depth(MaxPoints)) u_lbl (.i_clk, .i_we(w_lwe),
        .i_waddr(r_pi), .i_wdata(4'(r_best)), .i_raddr(w_lra), .o_rdata(w_lrd));

    logic w_acc_in;
    assign w_acc_in = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || o_valid;
    assign w_pwe    = w_acc_in && i_opcode == OpLoad && r_n < CntW'(MaxPoints);
    assign w_pwa    = r_n[PtAw-1:0];
    assign w_pra    = r_state == S_INIT ? PtAw'(r_cj) : r_pi;
    assign w_lra    = i_point_index[PtAw-1:0];
    assign w_lwe    = r_state == S_ACC;

    // A new result is loaded into the output register in these cases.
    logic w_out_load;
    assign w_out_load = (r_state == S_LBL) || (r_state == S_ERR) ||
                        (r_state == S_REP && (!o_valid || !i_stall));

    // Distance: difference on the selected axis; the square is registered.
    logic signed [32:0] w_da;
    logic [32:0]        w_ma;
    logic [65:0]        r_sq, r_dacc;
    logic signed [31:0] w_pa, w_ca, w_oa;
    always_comb begin
        case (r_axis)
            2'd0: begin w_pa = r_px; w_ca = r_cx[r_cj[ClAw-1:0]]; w_oa = r_nx; end
            2'd1: begin w_pa = r_py; w_ca = r_cy[r_cj[ClAw-1:0]]; w_oa = r_ny; end
            default: begin w_pa = r_pz; w_ca = r_cz[r_cj[ClAw-1:0]]; w_oa = r_nz; end
        endcase
        if (r_state == S_DCHK) begin
            w_da = 33'(w_oa) - 33'(w_ca);
        end else begin
            w_da = 33'(w_pa) - 33'(w_ca);
        end
        w_ma = w_da[32] ? 33'd0 - w_da : w_da;
    end

    // Divider.
    logic               w_div_start;
    logic               w_div_busy;
    logic signed [47:0] w_dnum;
    logic signed [31:0] w_q;
    always_comb begin
        case (r_axis)
            2'd0: w_dnum = r_sx[r_cj[ClAw-1:0]];
            2'd1: w_dnum = r_sy[r_cj[ClAw-1:0]];
            default: w_dnum = r_sz[r_cj[ClAw-1:0]];
        endcase
    end
    km3d_div u_div (.i_clk, .i_rst_n, .i_start(w_div_start), .i_num(w_dnum),
        .i_den(r_mc[r_cj[ClAw-1:0]]), .o_busy(w_div_busy), .o_quot(w_q));
    assign w_div_start = r_state == S_DIV && r_ph == 2'd0;

    logic [CntW-1:0] w_keff;
    assign w_keff = r_k_cfg > 5'(MaxClusters) ? CntW'(MaxClusters) : CntW'(r_k_cfg);
    logic [ClAw:0] w_klast;
    assign w_klast = r_k[ClAw:0] - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k_cfg  <= '0;
            r_thresh <= 32'd4295;
            r_iters  <= 8'd255;
            r_n      <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_K:      r_k_cfg  <= i_cfg_data[4:0];
                    CFG_THRESH: r_thresh <= i_cfg_data;
                    CFG_ITERS:  r_iters  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (w_out_load) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        if (i_opcode == OpRead) begin
                            r_state <= S_LBL;
                        end else begin
                            if (w_pwe) r_n <= r_n + 1'b1;
                            if (i_final_point) begin
                                r_cj <= '0;
                                r_k  <= w_keff;
                                r_passes <= '0;
                                r_conv <= 1'b0;
                                r_ph <= '0;
                                if (r_k_cfg == 5'd0) begin
                                    r_err_kind <= {2'd0, KIND_K_ZERO};
                                    r_state <= S_ERR;
                                end else if (w_keff > r_n + CntW'(w_pwe)) begin
                                    r_err_kind <= {2'd0, KIND_K_LARGE};
                                    r_state <= S_ERR;
                                end else begin
                                    r_state <= S_INIT;
                                end
                            end
                        end
                    end
                end
                S_LBL: begin
                    o_kind <= KIND_LABEL;
                    o_cluster <= w_lrd;
                    o_center_x <= '0; o_center_y <= '0; o_center_z <= '0;
                    o_member_count <= '0; o_passes_used <= '0;
                    o_converged <= 1'b0; o_last <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_ERR: begin
                    o_kind <= r_err_kind[1:0];
                    o_cluster <= '0;
                    o_center_x <= '0; o_center_y <= '0; o_center_z <= '0;
                    o_member_count <= '0; o_passes_used <= '0;
                    o_converged <= 1'b0; o_last <= 1'b1;
                    r_n <= '0;
                    r_state <= S_IDLE;
                end
                S_INIT: begin
                    // Address r_cj issued; data arrives in the following phase.
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_cx[r_cj[ClAw-1:0]] <= w_rx;
                        r_cy[r_cj[ClAw-1:0]] <= w_ry;
                        r_cz[r_cj[ClAw-1:0]] <= w_rz;
                        r_ph <= 2'd0;
                        if (r_cj == w_klast) begin
                            r_state <= S_PCLR;
                        end else begin
                            r_cj <= r_cj + 1'b1;
                        end
                    end
                end
                S_PCLR: begin
                    for (int j = 0; j < MaxClusters; j++) begin
                        r_sx[j] <= '0; r_sy[j] <= '0; r_sz[j] <= '0; r_mc[j] <= '0;
                    end
                    r_passes <= r_passes + 1'b1;
                    r_moved <= 1'b0;
                    r_pi <= '0;
                    r_ph <= '0;
                    r_state <= S_PT;
                end
                S_PT: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_px <= w_rx; r_py <= w_ry; r_pz <= w_rz;
                        r_cj <= '0; r_axis <= '0; r_ph <= '0;
                        r_dacc <= '0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // Phases: axis squares issued 0..2, then final sum compare.
                    if (r_ph == 2'd0) begin
                        r_sq <= 66'(w_ma * w_ma);
                        r_ph <= 2'd1;
                    end else begin
                        if (r_axis == 2'd2 && r_ph == 2'd2) begin
                            if (r_cj == '0 || r_dacc + r_sq < r_best_d) begin
                                r_best_d <= r_dacc + r_sq;
                                r_best <= r_cj[ClAw-1:0];
                            end
                            r_dacc <= '0;
                            r_axis <= '0;
                            r_ph <= '0;
                            if (r_cj == w_klast) begin
                                r_state <= S_ACC;
                            end else begin
                                r_cj <= r_cj + 1'b1;
                            end
                        end else if (r_axis == 2'd2) begin
                            r_ph <= 2'd2;
                        end else begin
                            r_dacc <= r_dacc + r_sq;
                            r_axis <= r_axis + 1'b1;
                            r_ph <= 2'd0;
                        end
                    end
                end
                S_ACC: begin
                    r_sx[r_best] <= r_sx[r_best] + 48'(r_px);
                    r_sy[r_best] <= r_sy[r_best] + 48'(r_py);
                    r_sz[r_best] <= r_sz[r_best] + 48'(r_pz);
                    r_mc[r_best] <= r_mc[r_best] + 1'b1;
                    r_ph <= '0;
                    if (CntW'(r_pi) == r_n - 1'b1) begin
                        r_cj <= '0;
                        r_axis <= '0;
                        r_state <= S_UPD;
                    end else begin
                        r_pi <= r_pi + 1'b1;
                        r_state <= S_PT;
                    end
                end
                S_UPD: begin
                    r_ph <= '0;
                    r_axis <= '0;
                    if (r_mc[r_cj[ClAw-1:0]] == '0) begin
                        if (r_cj == w_klast) begin
                            r_cj <= '0;
                            r_state <= S_REP;
                            if (!r_moved) r_conv <= 1'b1;
                            else if (r_passes < (r_iters == 8'd0 ? 8'd1 : r_iters))
                                r_state <= S_PCLR;
                        end else begin
                            r_cj <= r_cj + 1'b1;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        r_ph <= 2'd2;
                    end else if (!w_div_busy) begin
                        case (r_axis)
                            2'd0: r_nx <= w_q;
                            2'd1: r_ny <= w_q;
                            default: r_nz <= w_q;
                        endcase
                        r_ph <= '0;
                        if (r_axis == 2'd2) begin
                            r_axis <= '0;
                            r_dacc <= '0;
                            r_state <= S_DCHK;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end
                end
                S_DCHK: begin
                    if (r_ph == 2'd0) begin
                        r_sq <= 66'(w_ma * w_ma);
                        r_ph <= 2'd1;
                    end else if (r_axis != 2'd2) begin
                        r_dacc <= r_dacc + r_sq;
                        r_axis <= r_axis + 1'b1;
                        r_ph <= '0;
                    end else begin
                        if (r_dacc + r_sq > 66'(r_thresh)) r_moved <= 1'b1;
                        r_cx[r_cj[ClAw-1:0]] <= r_nx;
                        r_cy[r_cj[ClAw-1:0]] <= r_ny;
                        r_cz[r_cj[ClAw-1:0]] <= r_nz;
                        r_axis <= '0;
                        r_ph <= '0;
                        if (r_cj == w_klast) begin
                            r_cj <= '0;
                            r_state <= S_REP;
                            if (!(r_moved || r_dacc + r_sq > 66'(r_thresh)))
                                r_conv <= 1'b1;
                            else if (r_passes < (r_iters == 8'd0 ? 8'd1 : r_iters))
                                r_state <= S_PCLR;
                        end else begin
                            r_cj <= r_cj + 1'b1;
                            r_state <= S_UPD;
                        end
                    end
                end
                S_REP: begin
                    if (!o_valid || !i_stall) begin
                        o_kind <= KIND_CENTER;
                        o_cluster <= 4'(r_cj);
                        o_center_x <= r_cx[r_cj[ClAw-1:0]];
                        o_center_y <= r_cy[r_cj[ClAw-1:0]];
                        o_center_z <= r_cz[r_cj[ClAw-1:0]];
                        o_member_count <= 13'(r_mc[r_cj[ClAw-1:0]]);
                        o_passes_used <= r_passes;
                        o_converged <= r_conv;
                        o_last <= r_cj == w_klast;
                        if (r_cj == w_klast) begin
                            r_n <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cj <= r_cj + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/km3d_checker.sv */
// Port-level checker for the 3D k-means clustering unit, bound to the top
// level. Depends on km3d_pkg.
`timescale 1ns / 1ps
module km3d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [31:0] o_center_x,
    input logic [7:0]  o_passes_used,
    input logic        o_last
);
    import km3d_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_center_x))
        else $error("stalled result changed");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_CENTER |-> o_last)
        else $error("non-centre result not last");
    a_lbl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_CENTER |-> o_passes_used == 8'd0)
        else $error("reply carries passes");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
endmodule

bind kmeans_3d_point_clustering_unit km3d_checker u_km3d_checker (.*);

/* tb/km3d_checker.sv */
// Checker for the 3D k-means clustering unit: watches the configuration port and both
// channels, predicts every result and compares it field by field. Depends on km3d_pkg.
`timescale 1ns / 1ps
module tb_km3d_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic [11:0] i_point_index,
    input  logic        i_final_point,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_cluster,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    input  logic [12:0] i_member_count,
    input  logic [7:0]  i_passes_used,
    input  logic        i_converged,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import km3d_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  cluster;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [12:0] members;
        logic [7:0]  passes;
        logic        conv;
        logic        last;
    } t_report;

    t_report report_q[$];

    logic signed [31:0] pt_x[MaxPoints];
    logic signed [31:0] pt_y[MaxPoints];
    logic signed [31:0] pt_z[MaxPoints];
    logic [3:0]         label_mem[MaxPoints];
    logic signed [31:0] cen_x[MaxClusters];
    logic signed [31:0] cen_y[MaxClusters];
    logic signed [31:0] cen_z[MaxClusters];
    int unsigned        loaded;
    logic [4:0]         k_reg;
    logic [31:0]        thresh_reg;
    logic [7:0]         iters_reg;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        loaded       = 0;
        k_reg        = 5'd0;
        thresh_reg   = 32'd4295;
        iters_reg    = 8'd255;
    end

    function automatic void add_report(t_report r);
        report_q.insert(report_q.size(), r);
    endfunction

    function automatic logic [63:0] sq_diff(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        logic [63:0] m;
        d = longint'(a) - longint'(b);
        m = (d < 0) ? 64'(-d) : 64'(d);
        return m * m;
    endfunction

    function automatic logic [65:0] dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
                                            logic signed [31:0] az, logic signed [31:0] bx,
                                            logic signed [31:0] by, logic signed [31:0] bz);
        return {2'b0, sq_diff(ax, bx)} + {2'b0, sq_diff(ay, by)} + {2'b0, sq_diff(az, bz)};
    endfunction

    function automatic t_report error_report(t_kind kind);
        t_report r;
        r = '0;
        r.kind = kind;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_clustering();
        int unsigned n, k, cap, passes, best;
        logic conv, moved;
        longint sx[MaxClusters], sy[MaxClusters], sz[MaxClusters];
        int unsigned cnt[MaxClusters];
        logic [65:0] d, bd;
        logic signed [31:0] nx, ny, nz;
        t_report r;
        n = loaded;
        loaded = 0;
        k = k_reg;
        cap = (iters_reg != 0) ? iters_reg : 1;
        passes = 0;
        conv = 1'b0;
        if (k == 0) begin
            add_report(error_report(KIND_K_ZERO));
            return;
        end
        if (k > MaxClusters) k = MaxClusters;
        if (k > n) begin
            add_report(error_report(KIND_K_LARGE));
            return;
        end
        for (int j = 0; j < k; j++) begin
            cen_x[j] = pt_x[j];
            cen_y[j] = pt_y[j];
            cen_z[j] = pt_z[j];
        end
        forever begin
            moved = 1'b0;
            passes++;
            for (int j = 0; j < k; j++) begin
                sx[j] = 0;
                sy[j] = 0;
                sz[j] = 0;
                cnt[j] = 0;
            end
            for (int i = 0; i < n; i++) begin
                best = 0;
                bd = '0;
                for (int j = 0; j < k; j++) begin
                    d = dist_sq(pt_x[i], pt_y[i], pt_z[i], cen_x[j], cen_y[j], cen_z[j]);
                    if (j == 0 || d < bd) begin
                        best = j;
                        bd = d;
                    end
                end
                label_mem[i] = best[3:0];
                sx[best] += longint'(pt_x[i]);
                sy[best] += longint'(pt_y[i]);
                sz[best] += longint'(pt_z[i]);
                cnt[best]++;
            end
            for (int j = 0; j < k; j++) begin
                if (cnt[j] != 0) begin
                    // Signed division truncates toward zero, as the block does.
                    nx = 32'(sx[j] / longint'(cnt[j]));
                    ny = 32'(sy[j] / longint'(cnt[j]));
                    nz = 32'(sz[j] / longint'(cnt[j]));
                    if (dist_sq(nx, ny, nz, cen_x[j], cen_y[j], cen_z[j]) > {34'b0, thresh_reg})
                        moved = 1'b1;
                    cen_x[j] = nx;
                    cen_y[j] = ny;
                    cen_z[j] = nz;
                end
            end
            if (!moved) begin
                conv = 1'b1;
                break;
            end
            if (passes >= cap) break;
        end
        for (int j = 0; j < k; j++) begin
            r.kind    = KIND_CENTER;
            r.cluster = j[3:0];
            r.cx      = cen_x[j];
            r.cy      = cen_y[j];
            r.cz      = cen_z[j];
            r.members = cnt[j][12:0];
            r.passes  = passes[7:0];
            r.conv    = conv;
            r.last    = (j + 1 == k);
            add_report(r);
        end
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", field, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_K:      k_reg      = i_cfg_data[4:0];
                    CFG_THRESH: thresh_reg = i_cfg_data;
                    CFG_ITERS:  iters_reg  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (report_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 32'(i_kind), '0);
                end else begin
                    want = report_q.pop_front();
                    if (i_kind != want.kind)
                        report_mismatch("kind", 32'(i_kind), 32'(want.kind));
                    if (i_cluster != want.cluster)
                        report_mismatch("cluster", 32'(i_cluster), 32'(want.cluster));
                    if (i_center_x != want.cx) report_mismatch("center_x", i_center_x, want.cx);
                    if (i_center_y != want.cy) report_mismatch("center_y", i_center_y, want.cy);
                    if (i_center_z != want.cz) report_mismatch("center_z", i_center_z, want.cz);
                    if (i_member_count != want.members)
                        report_mismatch("member_count", 32'(i_member_count),
                                        32'(want.members));
                    if (i_passes_used != want.passes)
                        report_mismatch("passes_used", 32'(i_passes_used), 32'(want.passes));
                    if (i_converged != want.conv)
                        report_mismatch("converged", 32'(i_converged), 32'(want.conv));
                    if (i_last != want.last)
                        report_mismatch("last", 32'(i_last), 32'(want.last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_opcode != OpLoad) begin
                    want = error_report(KIND_LABEL);
                    want.cluster = label_mem[i_point_index];
                    add_report(want);
                end else begin
                    if (loaded < MaxPoints) begin
                        pt_x[loaded] = i_coord_x;
                        pt_y[loaded] = i_coord_y;
                        pt_z[loaded] = i_coord_z;
                        loaded++;
                    end
                    if (i_final_point) predict_clustering();
                end
            end
        end
        o_pending = report_q.size();
    end
endmodule

/* tb/tb_top.sv */
// Top of the testbench for the 3D k-means clustering unit: clock, reset, configuration
// and stimulus, and the verdict. Depends on km3d_pkg, tb_km3d_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
    import km3d_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_opcode = 1'b0;
    logic [31:0] i_coord_x = '0;
    logic [31:0] i_coord_y = '0;
    logic [31:0] i_coord_z = '0;
    logic [11:0] i_point_index = '0;
    logic        i_final_point = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_K;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [3:0]  o_cluster;
    logic [31:0] o_center_x, o_center_y, o_center_z;
    logic [12:0] o_member_count;
    logic [7:0]  o_passes_used;
    logic        o_converged, o_last;

    int fail_count, pending;
    int send_idle = 0;
    int recv_idle = 0;
    int label_limit = 0;
    int sent_random = 0;
    logic [31:0] base_x[4], base_y[4], base_z[4];

    always #6 i_clk = ~i_clk;

    kmeans_3d_point_clustering_unit dut (.*);

    tb_km3d_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_opcode, .i_coord_x, .i_coord_y, .i_coord_z, .i_point_index, .i_final_point,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_kind(o_kind), .i_cluster(o_cluster),
        .i_center_x(o_center_x), .i_center_y(o_center_y), .i_center_z(o_center_z),
        .i_member_count(o_member_count), .i_passes_used(o_passes_used),
        .i_converged(o_converged), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_idle);

    // A watchdog that reports failure and ends the simulation if it runs too long.
    initial begin
        #2_000_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [11:0] idx, logic fin);
        while ($urandom_range(99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_opcode      = op;
        i_coord_x     = x;
        i_coord_y     = y;
        i_coord_z     = z;
        i_point_index = idx;
        i_final_point = fin;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic load_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic fin);
        send_item(OpLoad, x, y, z, 12'($urandom), fin);
    endtask

    task automatic read_label(int idx, logic fin);
        send_item(OpRead, $urandom, $urandom, $urandom, idx[11:0], fin);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic configure(logic [31:0] k, logic [31:0] thr, logic [31:0] iters);
        wait_idle();
        write_cfg(CFG_K, k);
        write_cfg(CFG_THRESH, thr);
        write_cfg(CFG_ITERS, iters);
    endtask

    // Labels are only ever read for points that a completed run has labelled.
    function automatic void note_run(int n, int k);
        int ks;
        ks = (k > MaxClusters) ? MaxClusters : k;
        if (k != 0 && ks <= n && n > label_limit) label_limit = n;
    endfunction

    task automatic random_run();
        int n, k, b, spread;
        logic [31:0] thr, iters, x, y, z;
        n = $urandom_range(1, 28);
        case ($urandom_range(19))
            0:       k = 0;
            1:       k = $urandom_range(17, 31);
            2:       k = 16;
            3:       k = n + 1;
            default: k = $urandom_range(1, (n < 6) ? n : 6);
        endcase
        case ($urandom_range(5))
            0:       thr = 0;
            1:       thr = 32'hFFFF_FFFF;
            2:       thr = 4295;
            default: thr = $urandom;
        endcase
        case ($urandom_range(9))
            0:       iters = 0;
            1:       iters = 1;
            2:       iters = 255;
            default: iters = $urandom_range(2, 16);
        endcase
        // A large pass cap with a low threshold could take very long, so keep it bounded.
        if (iters == 255 && thr < 4295) thr = 4295;
        configure(k, thr, iters);
        spread = 1 << $urandom_range(4, 30);
        for (int j = 0; j < 4; j++) begin
            base_x[j] = $urandom;
            base_y[j] = $urandom;
            base_z[j] = $urandom;
        end
        for (int i = 0; i < n; i++) begin
            if (label_limit > 0 && $urandom_range(9) == 0) begin
                read_label($urandom_range(label_limit - 1), $urandom_range(1));
                sent_random++;
            end
            b = $urandom_range(3);
            if ($urandom_range(7) == 0) begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end else begin
                x = base_x[b] + 32'($urandom_range(spread));
                y = base_y[b] + 32'($urandom_range(spread));
                z = base_z[b] + 32'($urandom_range(spread));
            end
            load_point(x, y, z, i == n - 1);
            sent_random++;
        end
        note_run(n, k);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle = 26;
        recv_idle = 65;

        // Zero clusters gives an error.
        configure(0, 4295, 255);
        load_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
        note_run(1, 0);

        // More clusters than points gives the other error.
        configure(3, 4295, 255);
        load_point(32'h0, 32'hFFFF_FFFF, 32'h1, 1'b0);
        load_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        note_run(2, 3);

        // Extreme coordinates, a zero pass cap and a zero threshold.
        configure(2, 0, 0);
        load_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        load_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        load_point(32'h0, 32'h0, 32'h0, 1'b0);
        load_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        note_run(4, 2);
        for (int i = 0; i < 4; i++) read_label(i, i[0]);

        // A cluster count above the maximum saturates.
        configure(20, 32'hFFFF_FFFF, 255);
        for (int i = 0; i < 17; i++)
            load_point(32'(i % 3) << 20, 32'h8000_0000, 32'(-i), i == 16);
        note_run(17, 20);

        while (sent_random < 410) begin
            if (sent_random < 137) begin
                send_idle = 26;
                recv_idle = 65;
            end else if (sent_random < 274) begin
                send_idle = 65;
                recv_idle = 26;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_run();
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
